@@ src/smeu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smeu_pkg
// Shared types and constants of the stack machine execute unit.
// ----------------------------------------------------------------------------
package smeu_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned SpW        = $clog2(StackDepth + 1);
  localparam int unsigned AddrW      = $clog2(StackDepth);

  typedef enum logic [4:0] {
    OP_PUSH  = 5'd0,
    OP_ADD   = 5'd1,
    OP_SUB   = 5'd2,
    OP_MUL   = 5'd3,
    OP_DIV   = 5'd4,
    OP_MOD   = 5'd5,
    OP_NEG   = 5'd6,
    OP_PRINT = 5'd7,
    OP_DUP   = 5'd8,
    OP_DROP  = 5'd9,
    OP_SWAP  = 5'd10,
    OP_ROT   = 5'd11,
    OP_LT    = 5'd12,
    OP_LE    = 5'd13,
    OP_EQ    = 5'd14,
    OP_NE    = 5'd15,
    OP_GE    = 5'd16,
    OP_GT    = 5'd17,
    OP_AND   = 5'd18,
    OP_OR    = 5'd19,
    OP_NOT   = 5'd20
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  typedef struct packed {
    logic [4:0]         func;
    logic signed [31:0] literal;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               printed;
    logic signed [31:0] print_value;
    logic [6:0]         stack_depth;
    logic signed [31:0] top_value;
  } out_t;

  // Decoded request handed from front to back.
  typedef struct packed {
    logic [4:0]  func;
    logic [31:0] literal;
    logic [1:0]  need;   // entries read from the stack
    logic        grows;  // push or dup
    logic        nop;    // unused opcode
  } cmd_t;

endpackage

@@ src/smeu_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smeu_front
// Accepts requests and classifies them by operand count and stack growth.
// ----------------------------------------------------------------------------
module smeu_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  smeu_pkg::in_t     in_req_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output smeu_pkg::cmd_t    q_cmd_o
);

  always_comb begin
    q_cmd_o.func    = in_req_i.func;
    q_cmd_o.literal = in_req_i.literal;
    q_cmd_o.grows   = (in_req_i.func == smeu_pkg::OP_PUSH) ||
                      (in_req_i.func == smeu_pkg::OP_DUP);
    q_cmd_o.nop     = (in_req_i.func > smeu_pkg::OP_NOT);
    priority if (in_req_i.func == smeu_pkg::OP_PUSH) begin
      q_cmd_o.need = 2'd0;
    end else if (in_req_i.func == smeu_pkg::OP_DUP || in_req_i.func == smeu_pkg::OP_NEG ||
                 in_req_i.func == smeu_pkg::OP_PRINT || in_req_i.func == smeu_pkg::OP_DROP ||
                 in_req_i.func == smeu_pkg::OP_NOT) begin
      q_cmd_o.need = 2'd1;
    end else if (in_req_i.func == smeu_pkg::OP_ROT) begin
      q_cmd_o.need = 2'd3;
    end else if (in_req_i.func <= smeu_pkg::OP_OR) begin
      q_cmd_o.need = 2'd2;
    end else begin
      q_cmd_o.need = 2'd0;
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

@@ src/smeu_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smeu_queue
// Two-entry queue of decoded requests between front and back.
// ----------------------------------------------------------------------------
module smeu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  smeu_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output smeu_pkg::cmd_t pop_cmd_o
);

  smeu_pkg::cmd_t slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= push_cmd_i;
  end

  assign full_o    = cnt_q[1];
  assign valid_o   = (cnt_q != 2'd0);
  assign pop_cmd_o = slot_q[rptr_q];

endmodule

@@ src/smeu_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smeu_back
// Executes decoded requests on the stack memory; serial divider for div/mod.
// ----------------------------------------------------------------------------
module smeu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  smeu_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output smeu_pkg::out_t out_rsp_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_CALC  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_TOP   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  localparam int unsigned SpW   = smeu_pkg::SpW;
  localparam int unsigned AddrW = smeu_pkg::AddrW;

  state_e             state_q, state_d;
  logic [SpW-1:0]     sp_q, nsp_q;
  smeu_pkg::cmd_t     cmd_q;
  logic [1:0]         cnt_q, wn_q;
  logic [31:0]        opr_q [3];
  logic [AddrW-1:0]   wa_q [3];
  logic [31:0]        wd_q [3];
  logic [1:0]         status_q;
  logic               printed_q;
  logic [31:0]        pval_q;
  logic [32:0]        rem_q;
  logic [31:0]        quo_q, divb_q;
  logic [5:0]         dcnt_q;
  logic               neg_q_q, neg_r_q;
  smeu_pkg::out_t     out_q;

  logic [31:0]        mem [smeu_pkg::StackDepth];
  logic [31:0]        rdata_q;
  logic [AddrW-1:0]   raddr;
  logic               we;
  logic [AddrW-1:0]   waddr;
  logic [31:0]        wdata;

  logic [31:0] a, b, c, r;
  logic [32:0] rem_sh;
  logic [31:0] mag_q, mag_r;

  assign b = opr_q[0];
  assign a = opr_q[1];
  assign c = opr_q[2];

  always_comb begin
    unique case (cmd_q.func)
      smeu_pkg::OP_ADD: r = a + b;
      smeu_pkg::OP_SUB: r = a - b;
      smeu_pkg::OP_MUL: r = a * b;
      smeu_pkg::OP_LT:  r = {31'd0, $signed(a) <  $signed(b)};
      smeu_pkg::OP_LE:  r = {31'd0, $signed(a) <= $signed(b)};
      smeu_pkg::OP_EQ:  r = {31'd0, a == b};
      smeu_pkg::OP_NE:  r = {31'd0, a != b};
      smeu_pkg::OP_GE:  r = {31'd0, $signed(a) >= $signed(b)};
      smeu_pkg::OP_GT:  r = {31'd0, $signed(a) >  $signed(b)};
      smeu_pkg::OP_AND: r = {31'd0, (a == 32'd1) && (b == 32'd1)};
      smeu_pkg::OP_OR:  r = {31'd0, (a == 32'd1) || (b == 32'd1)};
      default:          r = 32'd0;
    endcase
  end

  assign rem_sh = {rem_q[31:0], quo_q[31]};
  assign mag_q  = neg_q_q ? (32'd0 - quo_q) : quo_q;
  assign mag_r  = neg_r_q ? (32'd0 - rem_q[31:0]) : rem_q[31:0];

  // Memory port control.
  always_comb begin
    raddr = (state_q == S_READ) ? AddrW'(sp_q - SpW'(cnt_q) - SpW'(1))
                                : AddrW'(nsp_q - SpW'(1));
    we    = (state_q == S_WRITE) && (cnt_q < wn_q);
    waddr = wa_q[cnt_q[1:0]];
    wdata = wd_q[cnt_q[1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (cmd_valid_i) begin
        state_d = (cmd_i.nop || (sp_q < SpW'(cmd_i.need)) ||
                   (cmd_i.grows && sp_q == SpW'(smeu_pkg::StackDepth))) ? S_WRITE : S_READ;
      end
      S_READ:  if (cnt_q == cmd_q.need) state_d = S_CALC;
      S_CALC:  state_d = ((cmd_q.func == smeu_pkg::OP_DIV || cmd_q.func == smeu_pkg::OP_MOD)
                          && b != 32'd0) ? S_DIV : S_WRITE;
      S_DIV:   if (dcnt_q == 6'd32) state_d = S_WRITE;
      S_WRITE: if (cnt_q == wn_q) state_d = S_TOP;
      S_TOP:   state_d = S_OUT;
      S_OUT:   if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
      nsp_q   <= '0;
      cnt_q   <= 2'd0;
      wn_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: if (cmd_valid_i) begin
          cnt_q <= 2'd0;
          wn_q  <= 2'd0;
          nsp_q <= sp_q;
        end
        S_READ: if (cnt_q != cmd_q.need) cnt_q <= cnt_q + 2'd1;
        S_CALC: begin
          cnt_q <= 2'd0;
          unique case (cmd_q.func)
            smeu_pkg::OP_PUSH, smeu_pkg::OP_DUP: begin
              wn_q <= 2'd1; nsp_q <= sp_q + SpW'(1);
            end
            smeu_pkg::OP_NEG:   wn_q <= 2'd1;
            smeu_pkg::OP_PRINT, smeu_pkg::OP_DROP: nsp_q <= sp_q - SpW'(1);
            smeu_pkg::OP_SWAP:  wn_q <= 2'd2;
            smeu_pkg::OP_ROT:   wn_q <= 2'd3;
            smeu_pkg::OP_NOT: begin
              if (b == 32'd1 || b == 32'd0) wn_q <= 2'd1;
              else                          nsp_q <= sp_q - SpW'(1);
            end
            smeu_pkg::OP_DIV, smeu_pkg::OP_MOD: begin
              if (b != 32'd0) begin
                wn_q <= 2'd1; nsp_q <= sp_q - SpW'(1);
              end
            end
            default: begin
              wn_q <= 2'd1; nsp_q <= sp_q - SpW'(1);
            end
          endcase
        end
        S_DIV:   ;
        S_WRITE: if (cnt_q != wn_q) cnt_q <= cnt_q + 2'd1;
                 else sp_q <= nsp_q;
        S_TOP:   ;
        S_OUT:   ;
        default: ;
      endcase
    end
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (cmd_valid_i) begin
        cmd_q     <= cmd_i;
        printed_q <= 1'b0;
        pval_q    <= 32'd0;
        priority if (cmd_i.nop)                                status_q <= smeu_pkg::ST_OK;
        else if (sp_q < SpW'(cmd_i.need))                      status_q <= smeu_pkg::ST_UNDER;
        else if (cmd_i.grows && sp_q == SpW'(smeu_pkg::StackDepth))
                                                               status_q <= smeu_pkg::ST_OVER;
        else                                                   status_q <= smeu_pkg::ST_OK;
      end
      S_READ: if (cnt_q != 2'd0) opr_q[cnt_q - 2'd1] <= rdata_q;
      S_CALC: begin
        unique case (cmd_q.func)
          smeu_pkg::OP_PUSH: begin wa_q[0] <= AddrW'(sp_q); wd_q[0] <= cmd_q.literal; end
          smeu_pkg::OP_DUP:  begin wa_q[0] <= AddrW'(sp_q); wd_q[0] <= b; end
          smeu_pkg::OP_NEG: begin
            wa_q[0] <= AddrW'(sp_q - SpW'(1)); wd_q[0] <= 32'd0 - b;
          end
          smeu_pkg::OP_PRINT: begin printed_q <= 1'b1; pval_q <= b; end
          smeu_pkg::OP_DROP: ;
          smeu_pkg::OP_SWAP: begin
            wa_q[0] <= AddrW'(sp_q - SpW'(2)); wd_q[0] <= b;
            wa_q[1] <= AddrW'(sp_q - SpW'(1)); wd_q[1] <= a;
          end
          smeu_pkg::OP_ROT: begin
            wa_q[0] <= AddrW'(sp_q - SpW'(3)); wd_q[0] <= a;
            wa_q[1] <= AddrW'(sp_q - SpW'(2)); wd_q[1] <= b;
            wa_q[2] <= AddrW'(sp_q - SpW'(1)); wd_q[2] <= c;
          end
          smeu_pkg::OP_NOT: begin
            wa_q[0] <= AddrW'(sp_q - SpW'(1)); wd_q[0] <= {31'd0, b == 32'd0};
          end
          smeu_pkg::OP_DIV, smeu_pkg::OP_MOD: begin
            // Divide magnitudes; fix signs at the end.
            wa_q[0] <= AddrW'(sp_q - SpW'(2));
            if (b == 32'd0) status_q <= smeu_pkg::ST_DIVZ;
            rem_q   <= 33'd0;
            quo_q   <= a[31] ? (32'd0 - a) : a;
            divb_q  <= b[31] ? (32'd0 - b) : b;
            neg_q_q <= a[31] ^ b[31];
            neg_r_q <= a[31];
            dcnt_q  <= 6'd0;
          end
          default: begin wa_q[0] <= AddrW'(sp_q - SpW'(2)); wd_q[0] <= r; end
        endcase
      end
      S_DIV: begin
        if (dcnt_q != 6'd32) begin
          dcnt_q <= dcnt_q + 6'd1;
          if (rem_sh >= {1'b0, divb_q}) begin
            rem_q <= rem_sh - {1'b0, divb_q};
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[30:0], 1'b0};
          end
        end else begin
          wd_q[0] <= (cmd_q.func == smeu_pkg::OP_DIV) ? mag_q : mag_r;
        end
      end
      S_TOP: begin
        out_q.status      <= status_q;
        out_q.printed     <= printed_q;
        out_q.print_value <= pval_q;
        out_q.stack_depth <= 7'(sp_q);
        out_q.top_value   <= (sp_q == '0) ? 32'd0 : rdata_q;
      end
      S_WRITE: ;
      S_OUT:   ;
      default: ;
    endcase
  end

  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i;
  assign out_valid_o = (state_q == S_OUT);
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(smeu_pkg::StackDepth))
    else $error("stack pointer beyond depth");

  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> state_q == S_IDLE)
    else $error("result not retired after acceptance");

  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == smeu_pkg::ST_OVER |->
    sp_q == SpW'(smeu_pkg::StackDepth))
    else $error("overflow reported on a stack that is not full");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> state_q == S_READ || state_q == S_WRITE)
    else $error("request popped without starting execution");
`endif

endmodule

@@ src/stack_machine_execute_unit.sv @@
`timescale 1ns / 1ps
// Sequence: an accepted request passes through issue, operand reads, compute, a serial
//   divide for div and mod by a nonzero divisor, stack writes and a top-of-stack read
//   before its result is valid; underflow, overflow and an unused opcode skip reads and compute.
// Throughput: one request at a time in the back end, set by its sequential state machine
//   and the serial divider; the front queue holds two requests meanwhile.
// Reset: asynchronous, active low; empties the stack and queue, memory is not cleared.
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Forth-style execute unit on a 64-entry stack of signed 32-bit values.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  smeu_pkg::in_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output smeu_pkg::out_t out_rsp_o
);

  logic           q_full, q_push, q_valid, q_pop;
  smeu_pkg::cmd_t q_in_cmd, q_out_cmd;

  // Front: classify each request and drop it into the queue.
  smeu_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_in_cmd)
  );

  // Queue: decouple acceptance from execution.
  smeu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_in_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (q_out_cmd)
  );

  // Back: run the operation on the stack and hold the result until taken.
  smeu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_out_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
